@@ rtl/core/dda_pkg.sv @@
// ----------------------------------------------------------------------------
// dda_pkg
// Shared constants and types for the DDA line rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int CoordBits     = 6;
  localparam int InFracBits    = 8;
  localparam int SlopeFracBits = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic skip;
    logic x_major;
    logic neg;
  } ctl_t;

endpackage

@@ rtl/core/dda_line_rasterizer.sv @@
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// DDA line rasterizer: one segment in, a stream of pixel words out.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i/in_ready_o with the two endpoints in unsigned
// fixed point (COORD_BITS integer, IN_FRAC_BITS fraction bits).
// Output channel: out_valid_o/out_ready_i, one word per pixel, last_o set on
// the final pixel of a segment.
// One segment is taken at a time; in_ready_o is high only while idle.
// Sequence: setup when a segment is accepted, then the serial slope divider
// (a COORD_BITS+SLOPE_FRAC_BITS-bit quotient), the slope load, then one pixel
// per cycle while the receiver takes them. Segments whose truncated endpoints
// coincide, or whose major span is zero, produce no words.
// A stalled receiver holds the output register; stepping pauses until it is
// taken. The last word may still wait while the next segment is accepted.
// Reset returns to idle with no word pending.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
  parameter int COORD_BITS = dda_pkg::CoordBits,
  parameter int IN_FRAC_BITS = dda_pkg::InFracBits,
  parameter int SLOPE_FRAC_BITS = dda_pkg::SlopeFracBits,
  localparam int InW = COORD_BITS + IN_FRAC_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [InW-1:0]        start_x_i,
  input  logic [InW-1:0]        start_y_i,
  input  logic [InW-1:0]        end_x_i,
  input  logic [InW-1:0]        end_y_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [COORD_BITS-1:0] pixel_x_o,
  output logic [COORD_BITS-1:0] pixel_y_o,
  output logic                  last_o
);

  localparam int NumW = COORD_BITS + SLOPE_FRAC_BITS;
  localparam int AccW = NumW + 2;
  localparam int ShUp = (SLOPE_FRAC_BITS >= IN_FRAC_BITS) ? SLOPE_FRAC_BITS - IN_FRAC_BITS : 0;
  localparam int ShDn = (SLOPE_FRAC_BITS >= IN_FRAC_BITS) ? 0 : IN_FRAC_BITS - SLOPE_FRAC_BITS;

  dda_pkg::state_e state_q, state_d;
  dda_pkg::ctl_t   set_ctl, ctl_q;

  logic [COORD_BITS-1:0] a1, a2, den;
  logic [InW-1:0]        b1, mag;
  logic [InW+ShUp-1:0]   mag_wide, b1_wide;
  logic [NumW-1:0]       num, b1_s, quot;
  logic                  div_start, div_done;

  logic [COORD_BITS-1:0] pos_q, end_q, pos_nxt, minor;
  logic signed [AccW-1:0] acc_q, slope_q, acc_sum, quot_ext;
  logic [COORD_BITS+1:0] ipart;
  logic                  accept, step, is_last;

  logic                  out_valid_q, last_q;
  logic [COORD_BITS-1:0] px_q, py_q;

  dda_setup #(
    .COORD_BITS  (COORD_BITS),
    .IN_FRAC_BITS(IN_FRAC_BITS)
  ) u_setup (
    .sx_i (start_x_i),
    .sy_i (start_y_i),
    .ex_i (end_x_i),
    .ey_i (end_y_i),
    .ctl_o(set_ctl),
    .a1_o (a1),
    .a2_o (a2),
    .den_o(den),
    .b1_o (b1),
    .mag_o(mag)
  );

  assign mag_wide = (InW + ShUp)'(mag) << ShUp;
  assign b1_wide = (InW + ShUp)'(b1) << ShUp;
  assign num = NumW'(mag_wide >> ShDn);
  assign b1_s = NumW'(b1_wide >> ShDn);

  dda_div #(
    .NUM_W(NumW),
    .DEN_W(COORD_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (num),
    .den_i  (den),
    .done_o (div_done),
    .quot_o (quot)
  );

  assign accept = in_valid_i && in_ready_o;

  assign acc_sum = acc_q + slope_q;
  assign ipart = acc_sum[AccW-1:SLOPE_FRAC_BITS];
  assign pos_nxt = pos_q + 1'b1;
  assign is_last = (pos_nxt == end_q);
  assign quot_ext = $signed({2'b00, quot});

  always_comb begin
    if (acc_sum[AccW-1]) begin
      minor = '0;
    end else if (ipart[COORD_BITS+1:COORD_BITS] != 2'b00) begin
      minor = '1;
    end else begin
      minor = ipart[COORD_BITS-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dda_pkg::ST_IDLE: begin
        if (accept && !set_ctl.skip) state_d = dda_pkg::ST_DIV;
      end
      dda_pkg::ST_DIV: begin
        if (div_done) state_d = dda_pkg::ST_EMIT;
      end
      dda_pkg::ST_EMIT: begin
        if (step && is_last) state_d = dda_pkg::ST_IDLE;
      end
      default: state_d = dda_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    div_start = 1'b0;
    step = 1'b0;
    unique case (state_q)
      dda_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        div_start = accept && !set_ctl.skip;
      end
      dda_pkg::ST_DIV: ;
      dda_pkg::ST_EMIT: step = !out_valid_q || out_ready_i;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dda_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      ctl_q <= set_ctl;
      pos_q <= a1;
      end_q <= a2;
      acc_q <= $signed({2'b00, b1_s});
    end
    if (state_q == dda_pkg::ST_DIV && div_done) begin
      slope_q <= ctl_q.neg ? -quot_ext : quot_ext;
    end
    if (step) begin
      acc_q <= acc_sum;
      pos_q <= pos_nxt;
      px_q <= ctl_q.x_major ? pos_nxt : minor;
      py_q <= ctl_q.x_major ? minor : pos_nxt;
      last_q <= is_last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_x_o = px_q;
  assign pixel_y_o = py_q;
  assign last_o = last_q;

endmodule

@@ rtl/core/dda_setup.sv @@
// ----------------------------------------------------------------------------
// dda_setup
// Picks the major axis, orders the endpoints and forms the minor magnitude.
// ----------------------------------------------------------------------------
module dda_setup #(
  parameter int COORD_BITS = dda_pkg::CoordBits,
  parameter int IN_FRAC_BITS = dda_pkg::InFracBits,
  localparam int InW = COORD_BITS + IN_FRAC_BITS
) (
  input  logic [InW-1:0]        sx_i,
  input  logic [InW-1:0]        sy_i,
  input  logic [InW-1:0]        ex_i,
  input  logic [InW-1:0]        ey_i,
  output dda_pkg::ctl_t         ctl_o,
  output logic [COORD_BITS-1:0] a1_o,
  output logic [COORD_BITS-1:0] a2_o,
  output logic [COORD_BITS-1:0] den_o,
  output logic [InW-1:0]        b1_o,
  output logic [InW-1:0]        mag_o
);

  logic [COORD_BITS-1:0] tsx, tsy, tex, tey;
  logic [COORD_BITS-1:0] ma1, ma2;
  logic [InW-1:0]        adx, ady, mb1, mb2;
  logic                  x_major, swap;

  assign tsx = sx_i[InW-1:IN_FRAC_BITS];
  assign tsy = sy_i[InW-1:IN_FRAC_BITS];
  assign tex = ex_i[InW-1:IN_FRAC_BITS];
  assign tey = ey_i[InW-1:IN_FRAC_BITS];

  assign adx = (sx_i > ex_i) ? sx_i - ex_i : ex_i - sx_i;
  assign ady = (sy_i > ey_i) ? sy_i - ey_i : ey_i - sy_i;
  assign x_major = (tsx != tex) && (ady < adx);

  assign ma1 = x_major ? tsx : tsy;
  assign ma2 = x_major ? tex : tey;
  assign mb1 = x_major ? sy_i : sx_i;
  assign mb2 = x_major ? ey_i : ex_i;
  assign swap = ma2 < ma1;

  always_comb begin
    a1_o = swap ? ma2 : ma1;
    a2_o = swap ? ma1 : ma2;
    b1_o = swap ? mb2 : mb1;
    den_o = a2_o - a1_o;
    ctl_o.x_major = x_major;
    ctl_o.neg = swap ? (mb1 < mb2) : (mb2 < mb1);
    mag_o = (mb1 > mb2) ? mb1 - mb2 : mb2 - mb1;
    ctl_o.skip = ((tsx == tex) && (tsy == tey)) || (ma1 == ma2);
  end

endmodule

@@ rtl/core/dda_div.sv @@
// ----------------------------------------------------------------------------
// dda_div
// Restoring divider, one quotient bit per cycle through a single subtractor.
// ----------------------------------------------------------------------------
module dda_div #(
  parameter int NUM_W = 22,
  parameter int DEN_W = 6
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] num_i,
  input  logic [DEN_W-1:0] den_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int CntW = $clog2(NUM_W + 1);

  logic             busy_q, done_q;
  logic [CntW-1:0]  cnt_q;
  logic [DEN_W-1:0] den_q, rem_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W:0]   trial;
  logic [DEN_W+1:0] diff;
  logic             fit;

  assign trial = {rem_q, quo_q[NUM_W-1]};
  assign diff = {1'b0, trial} - {2'b00, den_q};
  assign fit = ~diff[DEN_W+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= CntW'(NUM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CntW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], fit};
      rem_q <= fit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Testbench for dda_line_rasterizer. Segments go in over a valid/ready
// channel. Each accepted segment is rasterized here in the same fixed-point
// steps as the block, and the pixel words that come out are compared, field
// by field and in order, with the pixels predicted for it.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int CoordBits     = dda_pkg::CoordBits;
  localparam int InFracBits    = dda_pkg::InFracBits;
  localparam int SlopeFracBits = dda_pkg::SlopeFracBits;

  localparam int FixW          = CoordBits + InFracBits;
  localparam longint MaxCoord  = (64'sd1 << CoordBits) - 1;
  localparam int DrainCycles   = CoordBits + SlopeFracBits + 8;
  localparam int LongHold      = 400;
  localparam int WatchdogLimit = 3000;
  localparam int NumRandom     = 400;

  typedef logic [FixW-1:0]      fix_t;
  typedef logic [CoordBits-1:0] coord_t;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   last;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t expected_q[$];
    int     errors;

    function new();
      errors = 0;
    endfunction

    // DDA walk of one segment; pushes every pixel it emits.
    function void add_segment(fix_t sx, fix_t sy, fix_t ex, fix_t ey);
      longint x0, y0, x1, y1, tx0, ty0, tx1, ty1;
      longint adx, ady, a1, a2, b1, b2, tmp, mag, quo, slope, acc, minor, pos;
      bit     xmaj;
      pixel_t p;
      x0 = longint'(sx);
      y0 = longint'(sy);
      x1 = longint'(ex);
      y1 = longint'(ey);
      tx0 = x0 >> InFracBits;
      ty0 = y0 >> InFracBits;
      tx1 = x1 >> InFracBits;
      ty1 = y1 >> InFracBits;
      if (tx0 == tx1 && ty0 == ty1) return;
      adx = (x0 > x1) ? x0 - x1 : x1 - x0;
      ady = (y0 > y1) ? y0 - y1 : y1 - y0;
      xmaj = (tx0 != tx1) && (ady < adx);
      if (xmaj) begin
        a1 = tx0; a2 = tx1; b1 = y0; b2 = y1;
      end else begin
        a1 = ty0; a2 = ty1; b1 = x0; b2 = x1;
      end
      if (a2 < a1) begin
        tmp = a1; a1 = a2; a2 = tmp;
        tmp = b1; b1 = b2; b2 = tmp;
      end
      if (a1 == a2) return;
      mag = (b2 > b1) ? b2 - b1 : b1 - b2;
      quo = (mag << SlopeFracBits) / ((a2 - a1) << InFracBits);
      slope = (b2 < b1) ? -quo : quo;
      acc = (b1 << SlopeFracBits) >> InFracBits;
      for (pos = a1 + 1; pos <= a2; pos++) begin
        acc += slope;
        if (acc < 0) minor = 0;
        else minor = acc >>> SlopeFracBits;
        if (minor > MaxCoord) minor = MaxCoord;
        p.x = xmaj ? coord_t'(pos) : coord_t'(minor);
        p.y = xmaj ? coord_t'(minor) : coord_t'(pos);
        p.last = (pos == a2);
        expected_q.push_back(p);
      end
    endfunction

    function void check_pixel(coord_t x, coord_t y, logic last);
      pixel_t e;
      if (expected_q.size() == 0) begin
        $error("unexpected pixel word x=%0d y=%0d last=%0b", x, y, last);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (x !== e.x) begin
        $error("pixel_x: expected %0d, got %0d", e.x, x);
        errors++;
      end
      if (y !== e.y) begin
        $error("pixel_y: expected %0d, got %0d", e.y, y);
        errors++;
      end
      if (last !== e.last) begin
        $error("last: expected %0b, got %0b", e.last, last);
        errors++;
      end
    endfunction
  endclass

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   in_valid = 1'b0;
  logic   in_ready;
  fix_t   seg_sx = '0;
  fix_t   seg_sy = '0;
  fix_t   seg_ex = '0;
  fix_t   seg_ey = '0;
  logic   out_valid;
  logic   out_ready = 1'b0;
  coord_t pix_x;
  coord_t pix_y;
  logic   pix_last;

  int     tx_idle_pct = 12;
  int     rx_idle_pct = 70;
  logic   hold_req = 1'b0;
  logic   hold_taken = 1'b0;
  int     hold_left = 0;
  int     quiet_cycles = 0;

  pixel_scoreboard sb = new();

  dda_line_rasterizer uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .start_x_i  (seg_sx),
    .start_y_i  (seg_sy),
    .end_x_i    (seg_ex),
    .end_y_i    (seg_ey),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .pixel_x_o  (pix_x),
    .pixel_y_o  (pix_y),
    .last_o     (pix_last)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // receiver: random stalls, plus one long hold-off on request
  always @(posedge clk_i) begin
    if (hold_req && !hold_taken) begin
      hold_taken <= 1'b1;
      hold_left  <= LongHold;
      out_ready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (rx_idle_pct == 0) begin
      out_ready <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid && out_ready) sb.check_pixel(pix_x, pix_y, pix_last);
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= WatchdogLimit) begin
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic send_segment(fix_t sx, fix_t sy, fix_t ex, fix_t ey);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    seg_sx   <= sx;
    seg_sy   <= sy;
    seg_ex   <= ex;
    seg_ey   <= ey;
    do @(posedge clk_i); while (!in_ready);
    sb.add_segment(sx, sy, ex, ey);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  function automatic fix_t near_coord(fix_t c);
    int v;
    v = int'(c) + int'($urandom_range(0, 2047)) - 1024;
    if (v < 0) v = 0;
    if (v > (1 << FixW) - 1) v = (1 << FixW) - 1;
    return fix_t'(v);
  endfunction

  initial begin
    fix_t sx, sy, ex, ey;
    int   kind;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed segments
    send_segment(14'h0000, 14'h0000, 14'h0000, 14'h0000);
    send_segment(14'h0105, 14'h0210, 14'h01FF, 14'h02AA);
    send_segment(14'h0000, 14'h0000, 14'h3FFF, 14'h0000);
    send_segment(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h0000);
    send_segment(14'h0000, 14'h0000, 14'h3FFF, 14'h3FFF);
    send_segment(14'h3FFF, 14'h3FFF, 14'h3FFF, 14'h3FFF);
    send_segment(14'h00FF, 14'h0000, 14'h0100, 14'h00FF);
    send_segment(14'h0A00, 14'h0500, 14'h0AFF, 14'h0C40);
    send_segment(14'h0000, 14'h3F00, 14'h3F00, 14'h2000);
    send_segment(14'h3000, 14'h0100, 14'h0500, 14'h0A00);
    send_segment(14'h0580, 14'h0580, 14'h0680, 14'h05C0);
    send_segment(14'h3FFF, 14'h0000, 14'h0000, 14'h3FFF);
    send_segment(14'h00FF, 14'h00FF, 14'h3F00, 14'h1000);
    send_segment(14'h2080, 14'h1010, 14'h1D20, 14'h1030);
    send_segment(14'h0000, 14'h0000, 14'h0801, 14'h0800);
    send_segment(14'h2AAA, 14'h1555, 14'h1555, 14'h2AAA);
    send_segment(14'h1555, 14'h2AAA, 14'h3FFF, 14'h0000);
    send_segment(14'h0000, 14'h3FFF, 14'h00FF, 14'h0000);

    for (int i = 0; i < NumRandom; i++) begin
      if (i == NumRandom / 3) begin
        wait_drained();
        tx_idle_pct = 70;
        rx_idle_pct <= 12;
      end
      if (i == 2 * NumRandom / 3) begin
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        hold_req    <= 1'b1;
      end
      sx = fix_t'($urandom);
      sy = fix_t'($urandom);
      kind = $urandom_range(99);
      if (kind < 55) begin
        ex = near_coord(sx);
        ey = near_coord(sy);
      end else if (kind < 62) begin
        // same truncated y, truncated x equal or one step on (may give a zero major span)
        ex = {coord_t'(sx[FixW-1:InFracBits] + coord_t'($urandom_range(0, 1))),
              InFracBits'($urandom)};
        ey = {sy[FixW-1:InFracBits], InFracBits'($urandom)};
      end else begin
        ex = fix_t'($urandom);
        ey = fix_t'($urandom);
      end
      send_segment(sx, sy, ex, ey);
    end

    wait_drained();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dda_pkg.sv
rtl/core/dda_setup.sv
rtl/core/dda_div.sv
rtl/core/dda_line_rasterizer.sv
bench/tb_top.sv
